// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker module in rtl/bmp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, ignored while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/bmp_pkg.sv -----
package bmp_pkg;

    localparam int MOD_W = 31;
    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [2:0] {
        OP_NUM,
        OP_DEN,
        OP_ACC,
        OP_SQR,
        OP_FIN
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
        logic init_pow;
        logic post;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic trivial;
        logic loop_end;
        logic exp_zero;
        logic exp_bit;
        logic out_full;
    } t_stat;

endpackage

// ----- rtl/binomial_mod_prime.sv -----
// The sequencer runs k = min(r, n-r) numerator and denominator products, then raises the
// denominator to p-2 by square-and-multiply and takes a final product; trivial cases (r > n or p < 2) give zero.
// Throughput: one word at a time; each modular product runs on the single bit-serial
// multiply-reduce unit, which sets the rate.
// Reset (synchronous, active low) returns the sequencer to idle, empties the
// output register and loads the modulus with 1000000007.
module binomial_mod_prime #(
    parameter int N_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [N_BITS-1:0]         i_n_value,
    input  logic [N_BITS-1:0]         i_r_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [bmp_pkg::MOD_W-1:0] o_result,
    input  logic                      i_cfg_we,
    input  logic [bmp_pkg::MOD_W-1:0] i_cfg_wdata
);
    import bmp_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  load;

    assign load = i_valid && !o_stall;

    bmp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    bmp_datapath #(.N_BITS(N_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_n_value   (i_n_value),
        .i_r_value   (i_r_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

// ----- rtl/bmp_mulmod.sv -----
module bmp_mulmod (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [bmp_pkg::MOD_W-1:0] i_a,
    input  logic [bmp_pkg::MOD_W-1:0] i_b,
    input  logic [bmp_pkg::MOD_W-1:0] i_m,
    output logic                     o_done,
    output logic [bmp_pkg::MOD_W-1:0] o_y
);
    import bmp_pkg::*;

    localparam int CNT_W = $clog2(MOD_W);

    logic [MOD_W-1:0] r_a, r_b, r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [MOD_W:0]   dbl, dbl_red, sum, sum_red;

    // one bit of a per cycle, MSB first: acc = 2*acc + bit*b mod m
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        sum     = dbl_red + (r_a[MOD_W-1] ? {1'b0, r_b} : '0);
        sum_red = (sum >= {1'b0, i_m}) ? sum - {1'b0, i_m} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MOD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[MOD_W-2:0], 1'b0};
            r_acc <= sum_red[MOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_y    = r_acc;

endmodule

// ----- rtl/bmp_datapath.sv -----
module bmp_datapath #(
    parameter int N_BITS = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [N_BITS-1:0]         i_n_value,
    input  logic [N_BITS-1:0]         i_r_value,
    input  logic                      i_cfg_we,
    input  logic [bmp_pkg::MOD_W-1:0] i_cfg_wdata,
    input  bmp_pkg::t_cmd             i_cmd,
    output bmp_pkg::t_stat            o_stat,
    input  logic                      i_stall,
    output logic                      o_valid,
    output logic [bmp_pkg::MOD_W-1:0] o_result
);
    import bmp_pkg::*;

    logic [MOD_W-1:0]  r_mod, r_num, r_den, r_base, r_acc, r_exp, r_result;
    logic [N_BITS-1:0] r_i, r_k, r_lim;
    logic              r_triv, r_out_valid;
    logic [N_BITS-1:0] n_diff, n_lim;
    logic [MOD_W-1:0]  mul_a, mul_b, mul_y;
    logic              mul_done;

    always_comb begin
        n_diff = i_n_value - i_r_value;
        n_lim  = (n_diff < i_r_value) ? n_diff : i_r_value;
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_NUM: begin mul_a = MOD_W'(r_k);  mul_b = r_num; end
            OP_DEN: begin mul_a = MOD_W'(r_i);  mul_b = r_den; end
            OP_ACC: begin mul_a = r_base;       mul_b = r_acc; end
            OP_SQR: begin mul_a = r_base;       mul_b = r_base; end
            OP_FIN: begin mul_a = r_acc;        mul_b = r_num; end
            default: begin mul_a = '0;          mul_b = '0; end
        endcase
    end

    bmp_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (r_mod),
        .o_done  (mul_done),
        .o_y     (mul_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= MOD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_triv <= (i_r_value > i_n_value) || (r_mod[MOD_W-1:1] == '0);
            r_lim  <= n_lim;
            r_i    <= N_BITS'(1);
            r_k    <= i_n_value;
            r_num  <= MOD_W'(1);
            r_den  <= MOD_W'(1);
        end
        if (i_cmd.init_pow) begin
            r_exp  <= r_mod - MOD_W'(2);
            r_base <= r_den;
            r_acc  <= MOD_W'(1);
        end
        if (mul_done) begin
            unique case (i_cmd.op)
                OP_NUM: r_num <= mul_y;
                OP_DEN: begin
                    r_den <= mul_y;
                    r_i   <= r_i + 1'b1;
                    r_k   <= r_k - 1'b1;
                end
                OP_ACC: r_acc <= mul_y;
                OP_SQR: begin
                    r_base <= mul_y;
                    r_exp  <= r_exp >> 1;
                end
                OP_FIN: r_acc <= mul_y;
                default: ;
            endcase
        end
        if (i_cmd.post) begin
            r_result <= r_triv ? '0 : r_acc;
        end
    end

    always_comb begin
        o_stat.mul_done = mul_done;
        o_stat.trivial  = r_triv;
        o_stat.loop_end = r_i > r_lim;
        o_stat.exp_zero = r_exp == '0;
        o_stat.exp_bit  = r_exp[0];
        o_stat.out_full = r_out_valid && i_stall;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ----- rtl/bmp_ctrl.sv -----
module bmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  bmp_pkg::t_stat  i_stat,
    output bmp_pkg::t_cmd   o_cmd,
    output logic            o_stall
);
    import bmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_NUM,
        S_DEN,
        S_PINIT,
        S_PCHK,
        S_PACC,
        S_PSQR,
        S_FIN,
        S_POST
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '{start: 1'b0, op: OP_NUM, init_pow: 1'b0, post: 1'b0};
            r_stall <= 1'b0;
        end else begin
            r_cmd.start    <= 1'b0;
            r_cmd.init_pow <= 1'b0;
            r_cmd.post     <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_load) begin
                        r_stall <= 1'b1;
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    priority if (i_stat.trivial) begin
                        r_state <= S_POST;
                    end else if (i_stat.loop_end) begin
                        r_cmd.init_pow <= 1'b1;
                        r_state        <= S_PINIT;
                    end else begin
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_NUM;
                        r_state     <= S_NUM;
                    end
                end
                S_NUM: begin
                    if (i_stat.mul_done) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_DEN;
                        r_state     <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (i_stat.mul_done) begin
                        r_state <= S_LOOP;
                    end
                end
                S_PINIT: r_state <= S_PCHK;
                S_PCHK: begin
                    r_cmd.start <= 1'b1;
                    priority if (i_stat.exp_zero) begin
                        r_cmd.op <= OP_FIN;
                        r_state  <= S_FIN;
                    end else if (i_stat.exp_bit) begin
                        r_cmd.op <= OP_ACC;
                        r_state  <= S_PACC;
                    end else begin
                        r_cmd.op <= OP_SQR;
                        r_state  <= S_PSQR;
                    end
                end
                S_PACC: begin
                    if (i_stat.mul_done) begin
                        r_cmd.start <= 1'b1;
                        r_cmd.op    <= OP_SQR;
                        r_state     <= S_PSQR;
                    end
                end
                S_PSQR: begin
                    if (i_stat.mul_done) begin
                        r_state <= S_PCHK;
                    end
                end
                S_FIN: begin
                    if (i_stat.mul_done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    // hold until the output register can take the word
                    if (!i_stat.out_full) begin
                        r_cmd.post <= 1'b1;
                        r_stall    <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd   = r_cmd;
    assign o_stall = r_stall;

endmodule

// ----- rtl/bmp_checker.sv -----
`include "assert_macros.svh"

module bmp_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [bmp_pkg::MOD_W-1:0] o_result
);
    import bmp_pkg::*;

    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid && !o_stall)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_result))

endmodule

bind binomial_mod_prime bmp_checker u_bmp_checker (.*);

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_BITS = 20;
    localparam int MOD_W = bmp_pkg::MOD_W;
    localparam int N_MAX = (1 << N_BITS) - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    class binom_board;
        logic [MOD_W-1:0] prime;
        logic [MOD_W-1:0] coeff_q[$];
        int errors;

        function new();
            prime = bmp_pkg::MOD_RESET;
            errors = 0;
        endfunction

        // C(n, r) mod prime, with the factorial inverted by Fermat
        function logic [MOD_W-1:0] binom_mod(logic [N_BITS-1:0] n, logic [N_BITS-1:0] r);
            longint unsigned m, num, den, k, e, b, acc, i;
            m = prime;
            num = 1;
            den = 1;
            if (m < 2 || r > n) return '0;
            k = (n - r < r) ? n - r : r;
            for (i = 1; i <= k; i++) begin
                num = (num * (n - i + 1)) % m;
                den = (den * i) % m;
            end
            acc = 1 % m;
            b = den;
            e = m - 2;
            while (e != 0) begin
                if (e[0]) acc = (acc * b) % m;
                b = (b * b) % m;
                e = e >> 1;
            end
            return MOD_W'((num * acc) % m);
        endfunction

        function void note_word(logic [N_BITS-1:0] n, logic [N_BITS-1:0] r);
            coeff_q.insert(coeff_q.size(), binom_mod(n, r));
        endfunction

        task report(string what, logic [MOD_W-1:0] got, logic [MOD_W-1:0] want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(logic [MOD_W-1:0] got);
            logic [MOD_W-1:0] want;
            if (coeff_q.size() == 0) begin
                report("unexpected result", got, '0);
            end else begin
                want = coeff_q[0];
                coeff_q.delete(0);
                if (got !== want) report("result", got, want);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [N_BITS-1:0] i_n_value;
    logic [N_BITS-1:0] i_r_value;
    logic o_valid;
    logic i_stall;
    logic [MOD_W-1:0] o_result;
    logic i_cfg_we;
    logic [MOD_W-1:0] i_cfg_wdata;

    binom_board board;
    bit quiet;
    int idle_cycles;

    binomial_mod_prime #(.N_BITS(N_BITS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_n_value(i_n_value),
        .i_r_value(i_r_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_result(o_result),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function int draw_gap();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    task send_word(int n, int r);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_n_value = N_BITS'(n);
        i_r_value = N_BITS'(r);
        do @(posedge i_clk); while (o_stall);
        board.note_word(i_n_value, i_r_value);
        @(negedge i_clk);
    endtask

    task wait_drained();
        i_valid = 1'b0;
        while (board.coeff_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task write_prime(int unsigned value);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = MOD_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        board.prime = MOD_W'(value);
    endtask

    // mostly small k = min(r, n-r) of at most 12, plus r > n and small n and r
    task send_random();
        int n, r, k;
        case ($urandom_range(0, 9))
            0: begin
                n = $urandom_range(0, N_MAX - 1);
                r = $urandom_range(n + 1, N_MAX);
            end
            1: begin
                n = $urandom_range(0, 40);
                r = $urandom_range(0, 50);
            end
            default: begin
                n = $urandom_range(0, N_MAX);
                k = $urandom_range(0, 12);
                if (k > n) k = n;
                r = $urandom_range(0, 1) ? k : n - k;
            end
        endcase
        send_word(n, r);
    endtask

    task run_phase(int count);
        for (int i = 0; i < count; i++) begin
            // hold off until every expected word is back
            if (i == count / 2) wait_drained();
            send_random();
        end
    endtask

    // receive side
    initial begin
        int gap;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = draw_gap();
            if (gap > 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            board.check_word(o_result);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned primes[7] = '{2147483647, 3, 5, 13, 65537, 1000003, 1000000007};
        board = new();
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_n_value = '0;
        i_r_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // edges of n and r under the reset modulus
        send_word(0, 0);
        send_word(1, 0);
        send_word(1, 1);
        send_word(0, 1);
        send_word(0, N_MAX);
        send_word(N_MAX, 0);
        send_word(N_MAX, N_MAX);
        send_word(N_MAX, N_MAX - 1);
        send_word(N_MAX, 1);
        send_word(N_MAX - 1, N_MAX);
        send_word(N_MAX, 20);
        send_word(N_MAX, N_MAX - 20);
        send_word(5, 2);
        send_word(10, 3);
        send_word(20, 10);
        send_word(40, 20);
        send_word(3, 7);
        send_word(524288, 524287);
        send_word(699050, 699020);
        run_phase(60);

        for (int p = 0; p < 7; p++) begin
            write_prime(primes[p]);
            quiet = (p == 2 || p == 5);
            // n at or past the prime, for the small primes
            if (primes[p] < 20) begin
                send_word(primes[p] + 2, primes[p]);
                send_word(2 * primes[p], primes[p] - 1);
            end
            run_phase(70);
        end

        wait_drained();
        if (board.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
